### sv/bdq_pkg.sv
// Package for the bounded double-ended queue with linear search.
// Holds sizes, operation and status codes, request and result structs, and ring helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

   // Store geometry.
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = 5;
   localparam int VAL_W = 32;

   // Operation codes carried in a request.
   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_SEARCH     = 3'd4;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic [2:0]              op;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic             found;
      logic [CNT_W-1:0] count;
   } rsp_type;

   // Write and read commands from the sequencer to the entry store.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [VAL_W-1:0] wr_data;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

   // Ring position that lies off places behind base, with off below DEPTH.
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IDX_W+1)'(DEPTH)) begin
         sum = sum - (IDX_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // Ring position one place before base.
   function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
      logic [IDX_W-1:0] pos;
      if (base == '0) begin
         pos = IDX_W'(DEPTH - 1);
      end else begin
         pos = base - 1'b1;
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

### sv/bdq_ram.sv
// Entry store of the queue: one write port and one read port with registered read data.
// Depends on bdq_pkg for sizes and the command struct.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram (
   input  wire logic                      clock,
   input  wire bdq_pkg::ram_req_type      ram_req,
   output logic [bdq_pkg::VAL_W-1:0]      rd_data
);
   import bdq_pkg::*;

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/bdq_ctrl.sv
// Sequencer of the queue: ring pointers, operation decode and the shared compare unit
// that walks the stored entries one read per cycle during a search.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire bdq_pkg::req_type      req_data,
   output logic                       busy,
   output logic                       rsp_strobe,
   output bdq_pkg::rsp_type           rsp_data,
   output bdq_pkg::ram_req_type       ram_req,
   input  wire logic [bdq_pkg::VAL_W-1:0] rd_data
);
   import bdq_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [VAL_W-1:0] value_ff, value_in;
   rsp_type          rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   logic accept;
   logic full;
   logic empty;
   logic match;
   logic scan_done;
   logic issue;

   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   // Shared compare unit: the entry read last cycle against the searched value.
   assign match     = pend_ff && (rd_data == value_ff);
   assign scan_done = match || (!pend_ff && (scan_ff == count_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_data.op == OP_SEARCH) && !empty) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      busy  = 1'b0;
      issue = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
         end
         S_SCAN: begin
            busy  = 1'b1;
            issue = (scan_ff != count_ff) && !match;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // Pointer updates, store commands and the result of each request.
   always_comb begin
      front_in        = front_ff;
      count_in        = count_ff;
      scan_in         = scan_ff;
      pend_in         = issue;
      value_in        = value_ff;
      rsp_in          = rsp_ff;
      strobe_in       = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = ring_add(front_ff, count_ff[IDX_W-1:0]);
      ram_req.wr_data = req_data.value;
      ram_req.rd_addr = ring_add(front_ff, scan_ff[IDX_W-1:0]);

      if (issue) begin
         scan_in = scan_ff + 1'b1;
      end

      if (accept) begin
         strobe_in     = 1'b1;
         rsp_in.status = ST_OK;
         rsp_in.found  = 1'b0;
         unique case (req_data.op)
            OP_PUSH_BACK: begin
               if (full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  ram_req.wr_en = 1'b1;
                  count_in      = count_ff + 1'b1;
               end
            end
            OP_PUSH_FRONT: begin
               if (full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = ring_dec(front_ff);
                  front_in        = ring_dec(front_ff);
                  count_in        = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  front_in = ring_add(front_ff, IDX_W'(1));
                  count_in = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            OP_SEARCH: begin
               // A search over stored entries answers when the walk ends.
               if (!empty) begin
                  strobe_in = 1'b0;
                  value_in  = req_data.value;
                  scan_in   = '0;
                  pend_in   = 1'b0;
               end
            end
            default: begin
               rsp_in.status = ST_OK;
            end
         endcase
         rsp_in.count = count_in;
      end else if ((state_ff == S_SCAN) && scan_done) begin
         strobe_in     = 1'b1;
         rsp_in.status = ST_OK;
         rsp_in.found  = match;
         rsp_in.count  = count_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         front_ff  <= '0;
         count_ff  <= '0;
         scan_ff   <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         count_ff  <= count_in;
         scan_ff   <= scan_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

### sv/bounded_deque_with_search.sv
// Bounded double-ended queue of 16 signed 32-bit entries with a linear membership search.
// Pushes, pops and a search of an empty store give their result in the cycle after acceptance.
// A search walks the entries front to back, one store read and one compare per cycle,
// until a match or the last entry ends the walk; busy then falls as the result strobe rises.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Synchronous reset empties the queue; entry contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_search (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire bdq_pkg::req_type  req_data,
   output logic                   busy,
   output logic                   rsp_strobe,
   output bdq_pkg::rsp_type       rsp_data
);
   import bdq_pkg::*;

   ram_req_type      ram_req;
   logic [VAL_W-1:0] rd_data;

   // Sequencer and compare unit.
   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .ram_req    (ram_req),
      .rd_data    (rd_data)
   );

   // Entry store.
   bdq_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

`ifndef SYNTHESIS
   // Count never exceeds the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.count <= CNT_W'(DEPTH)))
      else $error("count above depth");

   // Every request other than a search answers in the next cycle.
   a_short_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.op != OP_SEARCH)) |=> rsp_strobe)
      else $error("missing result after push or pop");

   // The end of a search walk always delivers a result.
   a_scan_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("search ended without a result");

   // Only a successful search reports a hit.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.found) |-> (rsp_data.status == ST_OK))
      else $error("found set on a failed request");
`endif

endmodule

`default_nettype wire
